// File: design/octt_pkg.sv
`default_nettype none

package octt_pkg;

  localparam int NodeCountDef  = 64;
  localparam int TokenSlotsDef = 32;
  localparam int TokenBitsDef  = 16;

  localparam int KindW       = 2;
  localparam int NodeFieldW  = 7;
  localparam int NodeCmpW    = 9;
  localparam int TokenFieldW = 16;
  localparam int LaneW       = 4;
  localparam int MaskW       = 16;
  localparam int ReportNodeW = 6;

  localparam logic [KindW-1:0] EvSetupAck = KindW'(0);
  localparam logic [KindW-1:0] EvRelease  = KindW'(1);

  localparam logic [KindW-1:0] RepOpened   = KindW'(0);
  localparam logic [KindW-1:0] RepClosed   = KindW'(1);
  localparam logic [KindW-1:0] RepReleased = KindW'(2);

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StMatch,
    StCommit
  } state_e;

  typedef struct packed {
    logic bind_en;
    logic unbind;
  } slot_cmd_t;

endpackage

`default_nettype wire

// File: design/octt_pair_map.sv
`default_nettype none

module octt_pair_map #(
  parameter int AddrW = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic                  rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic             wr_data_i
);

  localparam int Depth = 1 << AddrW;

  logic mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// File: design/octt_slot_table.sv
`default_nettype none

module octt_slot_table #(
  parameter int TOKEN_SLOTS = 32,
  parameter int TokW        = 16,
  parameter int PairW       = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [TokW-1:0]        lookup_token_i,
  output logic                        hit_o,
  output logic [TOKEN_SLOTS-1:0]      hit_vec_o,
  output logic [PairW-1:0]            hit_pair_o,
  output logic                        free_o,
  output logic [TOKEN_SLOTS-1:0]      free_vec_o,
  input  wire logic [PairW-1:0]       still_pair_i,
  input  wire logic [TOKEN_SLOTS-1:0] still_excl_i,
  output logic                        still_o,
  input  wire octt_pkg::slot_cmd_t    cmd_i,
  input  wire logic [TOKEN_SLOTS-1:0] cmd_vec_i,
  input  wire logic [TokW-1:0]        cmd_token_i,
  input  wire logic [PairW-1:0]       cmd_pair_i
);

  import octt_pkg::*;

  logic [TOKEN_SLOTS-1:0] valid_q;
  logic [TokW-1:0]        token_q [TOKEN_SLOTS];
  logic [PairW-1:0]       pair_q  [TOKEN_SLOTS];

  logic [TOKEN_SLOTS-1:0] match_vec;
  logic [TOKEN_SLOTS-1:0] empty_vec;
  logic [TOKEN_SLOTS-1:0] same_pair_vec;

  always_comb begin
    for (int i = 0; i < TOKEN_SLOTS; i++) begin
      match_vec[i]     = valid_q[i] && (token_q[i] == lookup_token_i);
      same_pair_vec[i] = valid_q[i] && !still_excl_i[i] && (pair_q[i] == still_pair_i);
    end
  end

  assign empty_vec  = ~valid_q;
  // lowest set bit of each vector
  assign hit_vec_o  = match_vec & (~match_vec + TOKEN_SLOTS'(1));
  assign free_vec_o = empty_vec & (~empty_vec + TOKEN_SLOTS'(1));
  assign hit_o      = |match_vec;
  assign free_o     = |empty_vec;
  assign still_o    = |same_pair_vec;

  always_comb begin
    hit_pair_o = '0;
    for (int i = 0; i < TOKEN_SLOTS; i++) begin
      hit_pair_o = hit_pair_o | (pair_q[i] & {PairW{hit_vec_o[i]}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.bind_en) begin
      valid_q <= valid_q | cmd_vec_i;
    end else if (cmd_i.unbind) begin
      valid_q <= valid_q & ~cmd_vec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TOKEN_SLOTS; i++) begin
      if (cmd_i.bind_en && cmd_vec_i[i]) begin
        token_q[i] <= cmd_token_i;
        pair_q[i]  <= cmd_pair_i;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/optical_circuit_token_tracker_top.sv
// Optical circuit token tracker. Takes decoded setup-acknowledge and release
// events and keeps the active source-destination pairs in a one-bit pair map
// memory and the token bindings in a table of TOKEN_SLOTS slots. Events that
// are unwatched, carry a negative or out-of-range node, a zero token or an
// unknown kind are dropped with no report. Every accepted setup or release
// gives exactly one report. An event passes through a match state that
// searches the token table and reads the pair map, and a commit state that
// writes the pair map and the table back; a new event is taken in the commit
// state, so the block can take a new event while it commits the last one.
// A report waiting in the output register does not block the next match,
// only the following commit. After reset every one of the pair map's
// 2**(2*clog2(NODE_COUNT)) entries (4096 at 64 nodes) is swept to zero, one
// entry a cycle; in_ready_o stays low until the sweep is done.

`default_nettype none

module optical_circuit_token_tracker_top #(
  parameter int NODE_COUNT  = octt_pkg::NodeCountDef,
  parameter int TOKEN_SLOTS = octt_pkg::TokenSlotsDef,
  parameter int TOKEN_BITS  = octt_pkg::TokenBitsDef
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic                                   on_watched_signal_i,
  input  wire logic [octt_pkg::KindW-1:0]             event_kind_i,
  input  wire logic signed [octt_pkg::NodeFieldW-1:0] requester_node_i,
  input  wire logic signed [octt_pkg::NodeFieldW-1:0] target_node_i,
  input  wire logic [octt_pkg::TokenFieldW-1:0]       circuit_token_i,
  input  wire logic [octt_pkg::LaneW-1:0]             spatial_lane_i,
  input  wire logic [octt_pkg::MaskW-1:0]             wave_mask_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic [octt_pkg::KindW-1:0]                  report_kind_o,
  output logic [octt_pkg::ReportNodeW-1:0]            report_source_o,
  output logic [octt_pkg::ReportNodeW-1:0]            report_dest_o,
  output logic [octt_pkg::TokenFieldW-1:0]            report_token_o,
  output logic [octt_pkg::LaneW-1:0]                  report_lane_o,
  output logic [octt_pkg::MaskW-1:0]                  report_mask_o,
  output logic                                        newly_opened_o,
  output logic                                        table_full_o
);

  import octt_pkg::*;

  localparam int NodeW = $clog2(NODE_COUNT);
  localparam int PairW = 2 * NodeW;
  localparam int TokW  = TOKEN_BITS;

  localparam logic [NodeCmpW-1:0] NodeLimit = NodeCmpW'(NODE_COUNT);

  state_e state_q, state_d;

  logic [PairW-1:0] clr_cnt_q;

  // event registers
  logic             ev_release_q;
  logic [NodeW-1:0] ev_src_q;
  logic [NodeW-1:0] ev_dst_q;
  logic [TokW-1:0]  tok_q;
  logic [LaneW-1:0] lane_q;
  logic [MaskW-1:0] mask_q;

  // match results
  logic [PairW-1:0]       pair_q, pair_d;
  logic [TOKEN_SLOTS-1:0] sel_vec_q;
  logic                   hit_q;
  logic                   full_q;

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [KindW-1:0]       out_kind_q, out_kind_d;
  logic [PairW-1:0]       out_pair_q;
  logic [TokW-1:0]        out_tok_q;
  logic [LaneW-1:0]       out_lane_q;
  logic [MaskW-1:0]       out_mask_q;
  logic                   out_newly_q, out_newly_d;
  logic                   out_full_q, out_full_d;

  logic [TokW-1:0]     in_tok;
  logic [NodeCmpW-1:0] src_u, dst_u;
  logic                ev_ok;
  logic                in_fire;
  logic                out_free;

  logic                   hit;
  logic [TOKEN_SLOTS-1:0] hit_vec;
  logic [PairW-1:0]       hit_pair;
  logic                   free;
  logic [TOKEN_SLOTS-1:0] free_vec;
  logic [TOKEN_SLOTS-1:0] still_excl;
  logic                   still;
  slot_cmd_t              slot_cmd;

  logic             map_rd_en;
  logic             map_rd_data;
  logic             map_wr_en;
  logic [PairW-1:0] map_wr_addr;
  logic             map_wr_data;
  logic             close;
  logic             out_load;

  assign in_tok = TokW'(circuit_token_i);
  assign src_u  = NodeCmpW'($unsigned(requester_node_i));
  assign dst_u  = NodeCmpW'($unsigned(target_node_i));

  assign ev_ok = on_watched_signal_i
              && !requester_node_i[NodeFieldW-1] && !target_node_i[NodeFieldW-1]
              && (src_u < NodeLimit) && (dst_u < NodeLimit)
              && (in_tok != '0)
              && ((event_kind_i == EvSetupAck) || (event_kind_i == EvRelease));

  assign out_free = !out_valid_q || out_ready_i;
  assign in_fire  = in_valid_i && in_ready_o;

  octt_slot_table #(
    .TOKEN_SLOTS (TOKEN_SLOTS),
    .TokW        (TokW),
    .PairW       (PairW)
  ) u_slots (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lookup_token_i (tok_q),
    .hit_o          (hit),
    .hit_vec_o      (hit_vec),
    .hit_pair_o     (hit_pair),
    .free_o         (free),
    .free_vec_o     (free_vec),
    .still_pair_i   (pair_q),
    .still_excl_i   (still_excl),
    .still_o        (still),
    .cmd_i          (slot_cmd),
    .cmd_vec_i      (sel_vec_q),
    .cmd_token_i    (tok_q),
    .cmd_pair_i     (pair_q)
  );

  octt_pair_map #(
    .AddrW (PairW)
  ) u_map (
    .clk_i     (clk_i),
    .rd_en_i   (map_rd_en),
    .rd_addr_i (pair_d),
    .rd_data_o (map_rd_data),
    .wr_en_i   (map_wr_en),
    .wr_addr_i (map_wr_addr),
    .wr_data_i (map_wr_data)
  );

  // a released token no longer counts toward its own pair
  assign still_excl = hit_q ? sel_vec_q : '0;
  assign close      = ev_release_q && !still && map_rd_data;

  assign pair_d = (ev_release_q && hit) ? hit_pair : {ev_src_q, ev_dst_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: begin
        if (&clr_cnt_q) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_fire && ev_ok) begin
          state_d = StMatch;
        end
      end
      StMatch: begin
        state_d = StCommit;
      end
      StCommit: begin
        if (out_free) begin
          state_d = (in_fire && ev_ok) ? StMatch : StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o  = 1'b0;
    map_rd_en   = 1'b0;
    map_wr_en   = 1'b0;
    map_wr_addr = pair_q;
    map_wr_data = 1'b0;
    slot_cmd    = '0;
    out_load    = 1'b0;
    case (state_q)
      StClear: begin
        map_wr_en   = 1'b1;
        map_wr_addr = clr_cnt_q;
      end
      StIdle: begin
        in_ready_o = 1'b1;
      end
      StMatch: begin
        map_rd_en = 1'b1;
      end
      StCommit: begin
        if (out_free) begin
          in_ready_o = 1'b1;
          out_load   = 1'b1;
          if (ev_release_q) begin
            map_wr_en       = close;
            slot_cmd.unbind = hit_q;
          end else begin
            map_wr_en        = 1'b1;
            map_wr_data      = 1'b1;
            slot_cmd.bind_en = !full_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) begin
        clr_cnt_q <= clr_cnt_q + PairW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && ev_ok) begin
      ev_release_q <= (event_kind_i == EvRelease);
      ev_src_q     <= NodeW'(src_u);
      ev_dst_q     <= NodeW'(dst_u);
      tok_q        <= in_tok;
      lane_q       <= spatial_lane_i;
      mask_q       <= wave_mask_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StMatch) begin
      pair_q    <= pair_d;
      sel_vec_q <= hit ? hit_vec : free_vec;
      hit_q     <= hit;
      full_q    <= !hit && !free;
    end
  end

  // output transfer register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ev_release_q) begin
      out_kind_d  = close ? RepClosed : RepReleased;
      out_newly_d = 1'b0;
      out_full_d  = 1'b0;
    end else begin
      out_kind_d  = RepOpened;
      out_newly_d = !map_rd_data;
      out_full_d  = full_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q  <= out_kind_d;
      out_pair_q  <= pair_q;
      out_tok_q   <= tok_q;
      out_lane_q  <= lane_q;
      out_mask_q  <= mask_q;
      out_newly_q <= out_newly_d;
      out_full_q  <= out_full_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign report_kind_o   = out_kind_q;
  assign report_source_o = ReportNodeW'(out_pair_q[PairW-1:NodeW]);
  assign report_dest_o   = ReportNodeW'(out_pair_q[NodeW-1:0]);
  assign report_token_o  = TokenFieldW'(out_tok_q);
  assign report_lane_o   = out_lane_q;
  assign report_mask_o   = out_mask_q;
  assign newly_opened_o  = out_newly_q;
  assign table_full_o    = out_full_q;

endmodule

`default_nettype wire

// File: test/circuit_report_checker.sv
`default_nettype none

module circuit_report_checker #(
  parameter int NODE_COUNT  = octt_pkg::NodeCountDef,
  parameter int TOKEN_SLOTS = octt_pkg::TokenSlotsDef,
  parameter int TOKEN_BITS  = octt_pkg::TokenBitsDef
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  input  wire logic                                   in_ready_i,
  input  wire logic                                   on_watched_signal_i,
  input  wire logic [octt_pkg::KindW-1:0]             event_kind_i,
  input  wire logic signed [octt_pkg::NodeFieldW-1:0] requester_node_i,
  input  wire logic signed [octt_pkg::NodeFieldW-1:0] target_node_i,
  input  wire logic [octt_pkg::TokenFieldW-1:0]       circuit_token_i,
  input  wire logic [octt_pkg::LaneW-1:0]             spatial_lane_i,
  input  wire logic [octt_pkg::MaskW-1:0]             wave_mask_i,
  input  wire logic                                   out_valid_i,
  input  wire logic                                   out_ready_i,
  input  wire logic [octt_pkg::KindW-1:0]             report_kind_i,
  input  wire logic [octt_pkg::ReportNodeW-1:0]       report_source_i,
  input  wire logic [octt_pkg::ReportNodeW-1:0]       report_dest_i,
  input  wire logic [octt_pkg::TokenFieldW-1:0]       report_token_i,
  input  wire logic [octt_pkg::LaneW-1:0]             report_lane_i,
  input  wire logic [octt_pkg::MaskW-1:0]             report_mask_i,
  input  wire logic                                   newly_opened_i,
  input  wire logic                                   table_full_i,
  output int                                          mismatch_count_o,
  output int                                          awaited_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import octt_pkg::*;

  localparam int PairCount = NODE_COUNT * NODE_COUNT;

  typedef struct packed {
    logic [KindW-1:0]       kind;
    logic [ReportNodeW-1:0] src;
    logic [ReportNodeW-1:0] dst;
    logic [TokenFieldW-1:0] token;
    logic [LaneW-1:0]       lane;
    logic [MaskW-1:0]       mask;
    logic                   newly;
    logic                   full;
  } circuit_report_t;

  bit                     pair_live [PairCount];
  bit                     slot_used [TOKEN_SLOTS];
  logic [TokenFieldW-1:0] slot_tok  [TOKEN_SLOTS];
  int                     slot_pr   [TOKEN_SLOTS];

  circuit_report_t awaited_reports [$];
  int              mismatches = 0;
  int              awaited    = 0;

  assign mismatch_count_o = mismatches;
  assign awaited_count_o  = awaited;

  function automatic bit track_event(output circuit_report_t rep);
    int src;
    int dst;
    int pair;
    int slot;
    bit still;
    logic [TokenFieldW-1:0] tok;
    src  = int'(requester_node_i);
    dst  = int'(target_node_i);
    tok  = circuit_token_i & TokenFieldW'((64'd1 << TOKEN_BITS) - 1);
    rep       = '0;
    rep.token = tok;
    rep.lane  = spatial_lane_i;
    rep.mask  = wave_mask_i;
    if (!on_watched_signal_i || src < 0 || dst < 0 || tok == '0) return 1'b0;
    if (src >= NODE_COUNT || dst >= NODE_COUNT) return 1'b0;
    if (event_kind_i != EvSetupAck && event_kind_i != EvRelease) return 1'b0;
    pair = src * NODE_COUNT + dst;
    slot = -1;
    for (int i = 0; i < TOKEN_SLOTS; i++) begin
      if (slot < 0 && slot_used[i] && slot_tok[i] == tok) slot = i;
    end
    if (event_kind_i == EvSetupAck) begin
      rep.kind  = RepOpened;
      rep.newly = !pair_live[pair];
      pair_live[pair] = 1'b1;
      for (int i = 0; i < TOKEN_SLOTS; i++) begin
        if (slot < 0 && !slot_used[i]) slot = i;
      end
      if (slot < 0) begin
        rep.full = 1'b1;
      end else begin
        slot_used[slot] = 1'b1;
        slot_tok[slot]  = tok;
        slot_pr[slot]   = pair;
      end
    end else begin
      rep.kind = RepReleased;
      if (slot >= 0) begin
        pair            = slot_pr[slot] % PairCount;
        slot_used[slot] = 1'b0;
      end
      still = 1'b0;
      for (int i = 0; i < TOKEN_SLOTS; i++) begin
        if (slot_used[i] && slot_pr[i] == pair) still = 1'b1;
      end
      if (!still && pair_live[pair]) begin
        pair_live[pair] = 1'b0;
        rep.kind        = RepClosed;
      end
    end
    rep.src = ReportNodeW'(pair / NODE_COUNT);
    rep.dst = ReportNodeW'(pair % NODE_COUNT);
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : observe
    circuit_report_t want;
    circuit_report_t next_rep;
    if (!rst_ni) begin
      pair_live = '{default: 1'b0};
      slot_used = '{default: 1'b0};
      slot_tok  = '{default: '0};
      slot_pr   = '{default: 0};
      awaited_reports.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_reports.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected report, expected none, actual kind %0h token %0h",
                   $time, report_kind_i, report_token_i);
        end else begin
          want = awaited_reports.pop_front();
          check_field("report_kind", int'(want.kind), int'(report_kind_i));
          check_field("report_source", int'(want.src), int'(report_source_i));
          check_field("report_dest", int'(want.dst), int'(report_dest_i));
          check_field("report_token", int'(want.token), int'(report_token_i));
          check_field("report_lane", int'(want.lane), int'(report_lane_i));
          check_field("report_mask", int'(want.mask), int'(report_mask_i));
          check_field("newly_opened", int'(want.newly), int'(newly_opened_i));
          check_field("table_full", int'(want.full), int'(table_full_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (track_event(next_rep)) awaited_reports.push_back(next_rep);
      end
    end
    awaited = awaited_reports.size();
  end

endmodule

`default_nettype wire

// File: test/optical_circuit_token_tracker_top_test.sv
`default_nettype none

module optical_circuit_token_tracker_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  import octt_pkg::*;

  localparam logic [KindW-1:0] EvOther = 2'd2;
  localparam logic [KindW-1:0] EvSpare = 2'd3;
  localparam int CycleLimit = 200000;

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          in_valid    = 1'b0;
  logic                          in_ready;
  logic                          watched_sig = 1'b0;
  logic [KindW-1:0]              ev_kind     = '0;
  logic signed [NodeFieldW-1:0]  req_node    = '0;
  logic signed [NodeFieldW-1:0]  tgt_node    = '0;
  logic [TokenFieldW-1:0]        ev_token    = '0;
  logic [LaneW-1:0]              ev_lane     = '0;
  logic [MaskW-1:0]              ev_mask     = '0;
  logic                          out_valid;
  logic                          out_ready   = 1'b0;
  logic [KindW-1:0]              rep_kind;
  logic [ReportNodeW-1:0]        rep_source;
  logic [ReportNodeW-1:0]        rep_dest;
  logic [TokenFieldW-1:0]        rep_token;
  logic [LaneW-1:0]              rep_lane;
  logic [MaskW-1:0]              rep_mask;
  logic                          rep_newly;
  logic                          rep_full;
  int                            mismatch_count;
  int                            awaited_count;
  int                            sent = 0;

  optical_circuit_token_tracker_top u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .on_watched_signal_i (watched_sig),
    .event_kind_i        (ev_kind),
    .requester_node_i    (req_node),
    .target_node_i       (tgt_node),
    .circuit_token_i     (ev_token),
    .spatial_lane_i      (ev_lane),
    .wave_mask_i         (ev_mask),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .report_kind_o       (rep_kind),
    .report_source_o     (rep_source),
    .report_dest_o       (rep_dest),
    .report_token_o      (rep_token),
    .report_lane_o       (rep_lane),
    .report_mask_o       (rep_mask),
    .newly_opened_o      (rep_newly),
    .table_full_o        (rep_full)
  );

  circuit_report_checker u_report_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .on_watched_signal_i (watched_sig),
    .event_kind_i        (ev_kind),
    .requester_node_i    (req_node),
    .target_node_i       (tgt_node),
    .circuit_token_i     (ev_token),
    .spatial_lane_i      (ev_lane),
    .wave_mask_i         (ev_mask),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .report_kind_i       (rep_kind),
    .report_source_i     (rep_source),
    .report_dest_i       (rep_dest),
    .report_token_i      (rep_token),
    .report_lane_i       (rep_lane),
    .report_mask_i       (rep_mask),
    .newly_opened_i      (rep_newly),
    .table_full_i        (rep_full),
    .mismatch_count_o    (mismatch_count),
    .awaited_count_o     (awaited_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic push_event(input logic watched, input logic [KindW-1:0] kind,
                            input logic signed [NodeFieldW-1:0] src,
                            input logic signed [NodeFieldW-1:0] dst,
                            input logic [TokenFieldW-1:0] tok,
                            input logic [LaneW-1:0] lane, input logic [MaskW-1:0] mask);
    int gap;
    gap = ((sent / 50) % 4 == 3) ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    watched_sig <= watched;
    ev_kind     <= kind;
    req_node    <= src;
    tgt_node    <= dst;
    ev_token    <= tok;
    ev_lane     <= lane;
    ev_mask     <= mask;
    do @(posedge clk); while (!(in_valid && in_ready));
    sent++;
  endtask

  // receiver: random stalls, stall-free stretches, one long hold-off
  initial begin : drain
    int taken;
    int stall;
    taken = 0;
    forever begin
      stall = ((taken / 40) % 3 == 2) ? 0 : $urandom_range(0, 3);
      if (taken == 60) stall = 300;
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int live;
    int setup_pct;
    int pick;
    logic watched;
    logic [KindW-1:0] kind;
    logic signed [NodeFieldW-1:0] src;
    logic signed [NodeFieldW-1:0] dst;
    logic [TokenFieldW-1:0] tok;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // dropped events
    push_event(1'b0, EvSetupAck, 0, 0, 16'h0001, 4'h0, 16'h0000);
    push_event(1'b1, EvOther, 0, 0, 16'h0001, 4'hf, 16'hffff);
    push_event(1'b1, EvSpare, 0, 0, 16'h0001, 4'h1, 16'h0001);
    push_event(1'b1, EvSetupAck, -1, 0, 16'h0001, 4'h2, 16'h0002);
    push_event(1'b1, EvRelease, 0, -64, 16'h0001, 4'h3, 16'h0003);
    push_event(1'b1, EvSetupAck, 0, 0, 16'h0000, 4'h4, 16'h0004);
    // opens, repeat open, rebind of a bound token
    push_event(1'b1, EvSetupAck, 0, 0, 16'h0001, 4'h0, 16'h0000);
    push_event(1'b1, EvSetupAck, 63, 63, 16'hffff, 4'hf, 16'hffff);
    push_event(1'b1, EvSetupAck, 0, 0, 16'h0002, 4'h5, 16'ha5a5);
    push_event(1'b1, EvSetupAck, 1, 2, 16'h0001, 4'h3, 16'h5a5a);
    // releases: via binding, unbound token, pair still named
    push_event(1'b1, EvRelease, 7, 7, 16'h0001, 4'h6, 16'h1234);
    push_event(1'b1, EvRelease, 0, 0, 16'h0002, 4'h7, 16'h4321);
    push_event(1'b1, EvRelease, 0, 0, 16'hffff, 4'h8, 16'hffff);
    push_event(1'b1, EvRelease, 3, 3, 16'h0005, 4'h9, 16'h0f0f);
    push_event(1'b1, EvSetupAck, 5, 6, 16'h0007, 4'ha, 16'hf0f0);
    push_event(1'b1, EvSetupAck, 5, 6, 16'h0008, 4'hb, 16'h00ff);
    push_event(1'b1, EvRelease, 5, 6, 16'h0007, 4'hc, 16'hff00);
    push_event(1'b1, EvRelease, 5, 6, 16'h0008, 4'hd, 16'h8001);
    push_event(1'b1, EvSetupAck, 9, 9, 16'h000a, 4'he, 16'h7ffe);
    push_event(1'b1, EvRelease, 9, 9, 16'h000b, 4'h1, 16'h2468);
    push_event(1'b1, EvRelease, 9, 9, 16'h000a, 4'h2, 16'h1357);
    push_event(1'b1, EvRelease, 63, 0, 16'h8000, 4'h3, 16'hdead);

    // setup-heavy fills the token table, then balanced, then release-heavy
    for (int phase = 0; phase < 3; phase++) begin
      setup_pct = (phase == 0) ? 90 : (phase == 1) ? 50 : 20;
      live = 0;
      while (live < 105) begin
        watched = ($urandom_range(0, 19) != 0);
        if ($urandom_range(0, 99) < 5) begin
          kind = $urandom_range(0, 1) ? EvOther : EvSpare;
        end else begin
          kind = ($urandom_range(0, 99) < setup_pct) ? EvSetupAck : EvRelease;
        end
        pick = $urandom_range(0, 9);
        src  = NodeFieldW'((pick < 8) ? $urandom_range(0, 5) :
               (pick == 8) ? $urandom_range(0, 63) : $urandom_range(0, 127));
        pick = $urandom_range(0, 9);
        dst  = NodeFieldW'((pick < 8) ? $urandom_range(0, 5) :
               (pick == 8) ? $urandom_range(0, 63) : $urandom_range(0, 127));
        pick = $urandom_range(0, 9);
        tok  = TokenFieldW'((pick < 7) ? $urandom_range(1, 40) :
               (pick == 7) ? 0 : $urandom_range(0, 65535));
        if (watched && !kind[1] && !src[NodeFieldW-1] && !dst[NodeFieldW-1] && tok != '0)
          live++;
        push_event(watched, kind, src, dst, tok, LaneW'($urandom_range(0, 15)),
                   MaskW'($urandom_range(0, 65535)));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: optical_circuit_token_tracker_top.f
design/octt_pkg.sv
design/octt_pair_map.sv
design/octt_slot_table.sv
design/optical_circuit_token_tracker_top.sv
test/circuit_report_checker.sv
test/optical_circuit_token_tracker_top_test.sv
